/* hdl/esd_pkg.sv */
// Shared types, character codes and helper functions for the escaped string decoder.
// Used by esd_decode, esd_result_buf and escaped_string_decoder_core.
`default_nettype none

package esd_pkg;

   // Default width of the decoded length counter
   localparam int DEF_LENGTH_BITS = 16;
   // Width of the length field on the result port
   localparam int LEN_PORT_BITS = 16;
   // Highest count the length field can show
   localparam int LEN_PORT_MAX = 65535;

   // Escape modes
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_ESC    = 2'd1;
   localparam logic [1:0] MODE_HEX0   = 2'd2;
   localparam logic [1:0] MODE_HEX1   = 2'd3;

   // Character codes
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_A         = 8'h61;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_V         = 8'h76;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_UA        = 8'h41;
   localparam logic [7:0] CH_UF        = 8'h46;
   localparam logic [7:0] CH_X         = 8'h78;
   localparam logic [7:0] CH_UX        = 8'h58;

   // Control bytes
   localparam logic [7:0] CTL_LF  = 8'h0A;
   localparam logic [7:0] CTL_TAB = 8'h09;
   localparam logic [7:0] CTL_CR  = 8'h0D;
   localparam logic [7:0] CTL_NUL = 8'h00;
   localparam logic [7:0] CTL_BEL = 8'h07;
   localparam logic [7:0] CTL_BS  = 8'h08;
   localparam logic [7:0] CTL_VT  = 8'h0B;
   localparam logic [7:0] CTL_FF  = 8'h0C;

   localparam logic [7:0] HEX_TEN = 8'd10;

   // Maximum result words per input word
   localparam int MAX_WORDS = 3;

   typedef struct packed {
      logic [7:0]               data;
      logic                     byte_valid;
      logic                     run_end;
      logic                     string_end;
      logic [LEN_PORT_BITS-1:0] length;
   } esd_word_type;

   typedef struct packed {
      logic [1:0]                   count;
      esd_word_type [MAX_WORDS-1:0] word;
   } esd_bundle_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_A && c <= CH_F) ||
             (c >= CH_UA && c <= CH_UF);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] t;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         t = c - CH_ZERO;
      end else if (c >= CH_A && c <= CH_F) begin
         t = c - CH_A + HEX_TEN;
      end else begin
         t = c - CH_UA + HEX_TEN;
      end
      return t[3:0];
   endfunction

   function automatic logic [7:0] escape_map(input logic [7:0] c);
      logic [7:0] r;
      unique case (c)
         CH_N:    r = CTL_LF;
         CH_T:    r = CTL_TAB;
         CH_R:    r = CTL_CR;
         CH_ZERO: r = CTL_NUL;
         CH_A:    r = CTL_BEL;
         CH_B:    r = CTL_BS;
         CH_V:    r = CTL_VT;
         CH_F:    r = CTL_FF;
         default: r = c;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* hdl/esd_decode.sv */
// Escape decoder: escape state, held hex characters and length counter.
// Turns one registered input word into a bundle of up to three result words. Uses esd_pkg.
`default_nettype none

module esd_decode #(
   parameter int LENGTH_BITS = esd_pkg::DEF_LENGTH_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  take,
   input  wire logic [7:0]            in_byte,
   input  wire logic                  in_last,
   output esd_pkg::esd_bundle_type    bundle
);

   localparam int unsigned LimitInt = (LENGTH_BITS >= 16) ? esd_pkg::LEN_PORT_MAX
                                                          : ((1 << LENGTH_BITS) - 1);
   localparam logic [LENGTH_BITS-1:0] Limit = LENGTH_BITS'(LimitInt);
   localparam int WideBits = (LENGTH_BITS > esd_pkg::LEN_PORT_BITS) ? LENGTH_BITS
                                                                    : esd_pkg::LEN_PORT_BITS;

   logic [1:0]             mode_ff, mode_in;
   logic [7:0]             held_x_ff, held_x_in;
   logic [7:0]             held_digit_ff, held_digit_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;

   logic [7:0]             e [esd_pkg::MAX_WORDS];
   logic [1:0]             n;
   logic                   plain_emit;
   logic [1:0]             plain_mode;
   logic [LENGTH_BITS-1:0] sat [esd_pkg::MAX_WORDS];
   logic [WideBits-1:0]    wide [esd_pkg::MAX_WORDS];
   logic [WideBits-1:0]    wide_now;

   always_comb begin
      for (int k = 0; k < esd_pkg::MAX_WORDS; k++) begin
         sat[k] = (count_ff > Limit - LENGTH_BITS'(k + 1)) ? Limit
                                                          : count_ff + LENGTH_BITS'(k + 1);
         wide[k] = WideBits'(sat[k]);
      end
      wide_now = WideBits'(count_ff);
   end

   always_comb begin
      plain_emit    = (in_byte != esd_pkg::CH_BACKSLASH);
      plain_mode    = plain_emit ? esd_pkg::MODE_NORMAL : esd_pkg::MODE_ESC;
      e[0]          = in_byte;
      e[1]          = in_byte;
      e[2]          = in_byte;
      n             = 2'd0;
      mode_in       = esd_pkg::MODE_NORMAL;
      held_x_in     = held_x_ff;
      held_digit_in = held_digit_ff;

      unique case (mode_ff)
         esd_pkg::MODE_NORMAL: begin
            n       = {1'b0, plain_emit};
            mode_in = plain_mode;
         end
         esd_pkg::MODE_ESC: begin
            if (in_byte == esd_pkg::CH_X || in_byte == esd_pkg::CH_UX) begin
               held_x_in = in_byte;
               mode_in   = esd_pkg::MODE_HEX0;
            end else begin
               e[0] = esd_pkg::escape_map(in_byte);
               n    = 2'd1;
            end
         end
         esd_pkg::MODE_HEX0: begin
            if (esd_pkg::is_hex(in_byte)) begin
               held_digit_in = in_byte;
               mode_in       = esd_pkg::MODE_HEX1;
            end else begin
               e[0]    = held_x_ff;
               n       = 2'd1 + {1'b0, plain_emit};
               mode_in = plain_mode;
            end
         end
         default: begin
            if (esd_pkg::is_hex(in_byte)) begin
               e[0] = {esd_pkg::hex_val(held_digit_ff), esd_pkg::hex_val(in_byte)};
               n    = 2'd1;
            end else begin
               e[0]    = held_x_ff;
               e[1]    = held_digit_ff;
               n       = 2'd2 + {1'b0, plain_emit};
               mode_in = plain_mode;
            end
         end
      endcase

      // string ends inside a hex escape: flush held characters literally
      if (in_last && mode_in == esd_pkg::MODE_HEX0) begin
         e[0] = held_x_in;
         n    = 2'd1;
      end else if (in_last && mode_in == esd_pkg::MODE_HEX1) begin
         e[0] = held_x_in;
         e[1] = held_digit_in;
         n    = 2'd2;
      end

      for (int k = 0; k < esd_pkg::MAX_WORDS; k++) begin
         bundle.word[k].byte_valid = (2'(k) < n);
         bundle.word[k].data       = (2'(k) < n) ? e[k] : 8'd0;
         bundle.word[k].run_end    = (2'(k + 1) == n);
         bundle.word[k].string_end = (2'(k + 1) == n) && in_last;
         bundle.word[k].length     = wide[k][esd_pkg::LEN_PORT_BITS-1:0];
      end
      bundle.count = n;

      // last word that decodes to nothing still closes the string
      if (in_last && n == 2'd0) begin
         bundle.count              = 2'd1;
         bundle.word[0].run_end    = 1'b1;
         bundle.word[0].string_end = 1'b1;
         bundle.word[0].length     = wide_now[esd_pkg::LEN_PORT_BITS-1:0];
      end

      if (in_last) begin
         count_in = '0;
      end else if (n == 2'd0) begin
         count_in = count_ff;
      end else begin
         count_in = sat[n - 2'd1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= esd_pkg::MODE_NORMAL;
         held_x_ff     <= 8'd0;
         held_digit_ff <= 8'd0;
         count_ff      <= '0;
      end else if (take) begin
         if (in_last) begin
            mode_ff       <= esd_pkg::MODE_NORMAL;
            held_x_ff     <= 8'd0;
            held_digit_ff <= 8'd0;
         end else begin
            mode_ff       <= mode_in;
            held_x_ff     <= held_x_in;
            held_digit_ff <= held_digit_in;
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/esd_result_buf.sv */
// Result buffer: holds one bundle of up to three result words and hands them out
// one a cycle while rsp_ready is high. Uses esd_pkg types.
`default_nettype none

module esd_result_buf (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire esd_pkg::esd_bundle_type bundle,
   input  wire logic                    rsp_ready,
   output logic                         rsp_valid,
   output esd_pkg::esd_word_type        head_word,
   output logic                         free
);

   esd_pkg::esd_word_type words_ff [esd_pkg::MAX_WORDS];
   logic [1:0]            left_ff, left_in;
   logic [1:0]            head_ff, head_in;
   logic                  pop;

   assign rsp_valid = (left_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;
   assign free      = (left_ff == 2'd0) || (left_ff == 2'd1 && rsp_ready);
   assign head_word = words_ff[head_ff];

   always_comb begin
      left_in = left_ff;
      head_in = head_ff;
      if (load && bundle.count != 2'd0) begin
         left_in = bundle.count;
         head_in = 2'd0;
      end else if (pop) begin
         left_in = left_ff - 2'd1;
         if (left_ff != 2'd1) begin
            head_in = head_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 2'd0;
         head_ff <= 2'd0;
      end else begin
         left_ff <= left_in;
         head_ff <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && bundle.count != 2'd0) begin
         for (int k = 0; k < esd_pkg::MAX_WORDS; k++) begin
            words_ff[k] <= bundle.word[k];
         end
      end
   end

endmodule

`default_nettype wire

/* hdl/escaped_string_decoder_core.sv */
// Top level of the escaped string decoder: input register, decoder and result buffer.
// Depends on esd_pkg, esd_decode and esd_result_buf.
`default_nettype none

// Decodes the content bytes of a quoted string literal, one byte per word, with
// req_in_last on the final byte. Backslash escapes n t r 0 a b v f give control
// bytes, backslash x/X with two hex digits gives one byte, any other escaped
// character stands for itself and a trailing lone backslash is dropped. A hex
// escape cut short, or cut off by the end of the string, comes out literally.
// A word enters the input register, is decoded into a bundle of zero to three result
// words once the result buffer is free, and the bundle is registered in the result
// buffer that drives the rsp_ port. Words that decode to at most one byte stream at
// one per cycle while rsp_ready is high; a word with several results holds the buffer
// until the last is taken, stalling the input. Words that yield nothing (a backslash,
// the x of a hex escape, the first hex digit) produce no result unless they end the
// string; a final backslash gives a single result with rsp_byte_valid low that carries
// the final length, and a final x or hex digit comes out literally. rsp_decoded_length
// counts decoded bytes of the current string, including the one shown, and saturates;
// it restarts from zero after each string end.
module escaped_string_decoder_core #(
   parameter int LENGTH_BITS = esd_pkg::DEF_LENGTH_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [7:0]                          req_in_byte,
   input  wire logic                                req_in_last,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [7:0]                               rsp_out_byte,
   output logic                                     rsp_byte_valid,
   output logic                                     rsp_run_end,
   output logic                                     rsp_string_end,
   output logic [esd_pkg::LEN_PORT_BITS-1:0]        rsp_decoded_length
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   logic                    take;    // decoder consumes the registered word
   logic                    buf_free;
   esd_pkg::esd_bundle_type bundle;
   esd_pkg::esd_word_type   head_word;

   // the registered word moves on whenever the buffer will be empty this cycle
   assign take      = in_valid_ff && buf_free;
   assign req_ready = !in_valid_ff || take;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_in_last;
      end
   end

   esd_decode #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_decode (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .in_byte (in_byte_ff),
      .in_last (in_last_ff),
      .bundle  (bundle)
   );

   esd_result_buf u_result_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (take),
      .bundle    (bundle),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .head_word (head_word),
      .free      (buf_free)
   );

   assign rsp_out_byte       = head_word.data;
   assign rsp_byte_valid     = head_word.byte_valid;
   assign rsp_run_end        = head_word.run_end;
   assign rsp_string_end     = head_word.string_end;
   assign rsp_decoded_length = head_word.length;

endmodule

`default_nettype wire

/* hdl/esd_checker.sv */
// Port-level checks for escaped_string_decoder_core, and the bind that attaches them.
// Depends on esd_pkg for the length width.
`default_nettype none

module esd_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic [7:0]                         rsp_out_byte,
   input wire logic                               rsp_byte_valid,
   input wire logic                               rsp_run_end,
   input wire logic                               rsp_string_end,
   input wire logic [esd_pkg::LEN_PORT_BITS-1:0]  rsp_decoded_length
);

   // nothing on the result port straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word shown right after reset");

   // string end always closes the run of its input word
   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end |-> rsp_run_end)
      else $error("string end without run end");

   // an empty result only ever closes a string, with a zero byte
   a_empty_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_string_end && rsp_out_byte == 8'd0)
      else $error("empty result that does not end a string");

   // a stalled result word holds
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
                                 && $stable(rsp_decoded_length))
      else $error("result word changed while stalled");

endmodule

bind escaped_string_decoder_core esd_checker u_esd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_out_byte       (rsp_out_byte),
   .rsp_byte_valid     (rsp_byte_valid),
   .rsp_run_end        (rsp_run_end),
   .rsp_string_end     (rsp_string_end),
   .rsp_decoded_length (rsp_decoded_length)
);

`default_nettype wire
